[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies another in the same cycle
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

[rtl/iad_pkg.sv]
// Package with operation codes and transaction types for the integer ALU
`timescale 1ns / 1ps
package iad_pkg;
   typedef enum logic [4:0] {
      OP_ADD = 5'd0, OP_SUB = 5'd1, OP_AND = 5'd2, OP_OR = 5'd3, OP_XOR = 5'd4,
      OP_DIVS = 5'd5, OP_DIVU = 5'd6, OP_REMS = 5'd7, OP_REMU = 5'd8,
      OP_MULLS = 5'd9, OP_MULLU = 5'd10, OP_MULHS = 5'd11, OP_MULHU = 5'd12,
      OP_SLTS = 5'd13, OP_SLTU = 5'd14, OP_SLL = 5'd15, OP_SRL = 5'd16,
      OP_SRA = 5'd17, OP_EQ = 5'd18, OP_NEQ = 5'd19, OP_GT = 5'd20,
      OP_GTE = 5'd21, OP_LT = 5'd22, OP_LTE = 5'd23, OP_SEXT = 5'd24
   } op_type;

   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
   } class_type;

   // classified transaction passed from front to back
   typedef struct packed {
      class_type  cls;
      logic [4:0] mode;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] simple;
      logic       ovf;
      logic       dz;
   } item_type;

   typedef struct packed {
      logic [31:0] result;
      logic        overflow;
      logic        divide_by_zero;
   } rsp_type;

   localparam int unsigned WORD = 32;
endpackage

[rtl/iad_front.sv]
// Front end: classify the transaction and compute the simple (non-multiply, non-divide) operations
`timescale 1ns / 1ps
module iad_front (
   input  logic [4:0]  mode,
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   input  logic [4:0]  shift_amount,
   input  logic [5:0]  extend_width,
   output iad_pkg::item_type item
);
   logic [32:0] sum;
   logic [32:0] dif;
   logic        lts;
   logic        ltu;
   logic [31:0] upper;
   logic [31:0] sx;
   logic [4:0]  sbit;

   always_comb begin
      sum = {1'b0, operand_a} + {1'b0, operand_b};
      dif = {1'b0, operand_a} - {1'b0, operand_b};
      ltu = dif[32];
      lts = (operand_a[31] != operand_b[31]) ? operand_a[31] : dif[31];
      sbit = 5'(extend_width - 6'd1);
      upper = 32'hFFFFFFFF << extend_width[4:0];
      if (extend_width == 6'd0 || extend_width >= 6'd32) begin
         sx = operand_a;
      end else if (operand_a[sbit]) begin
         sx = operand_a | upper;
      end else begin
         sx = operand_a & ~upper;
      end
      item.mode = mode;
      item.a = operand_a;
      item.b = operand_b;
      item.simple = '0;
      item.ovf = 1'b0;
      item.dz = 1'b0;
      item.cls = iad_pkg::CLS_SIMPLE;
      case (mode)
         iad_pkg::OP_ADD: begin
            item.simple = sum[31:0];
            item.ovf = ~(operand_a[31] ^ operand_b[31]) & (operand_a[31] ^ sum[31]);
         end
         iad_pkg::OP_SUB: begin
            item.simple = dif[31:0];
            item.ovf = (operand_a[31] ^ operand_b[31]) & (operand_a[31] ^ dif[31]);
         end
         iad_pkg::OP_AND: item.simple = operand_a & operand_b;
         iad_pkg::OP_OR:  item.simple = operand_a | operand_b;
         iad_pkg::OP_XOR: item.simple = operand_a ^ operand_b;
         iad_pkg::OP_DIVS, iad_pkg::OP_DIVU, iad_pkg::OP_REMS, iad_pkg::OP_REMU: begin
            item.cls = iad_pkg::CLS_DIV;
            item.dz = (operand_b == 32'd0);
         end
         iad_pkg::OP_MULLS, iad_pkg::OP_MULLU, iad_pkg::OP_MULHS, iad_pkg::OP_MULHU:
            item.cls = iad_pkg::CLS_MUL;
         iad_pkg::OP_SLTS, iad_pkg::OP_LT: item.simple = {31'd0, lts};
         iad_pkg::OP_SLTU: item.simple = {31'd0, ltu};
         iad_pkg::OP_SLL: item.simple = operand_a << shift_amount;
         iad_pkg::OP_SRL: item.simple = operand_a >> shift_amount;
         iad_pkg::OP_SRA: item.simple = $unsigned($signed(operand_a) >>> shift_amount);
         iad_pkg::OP_EQ:  item.simple = {31'd0, operand_a == operand_b};
         iad_pkg::OP_NEQ: item.simple = {31'd0, operand_a != operand_b};
         iad_pkg::OP_GT:  item.simple = {31'd0, ~lts & (operand_a != operand_b)};
         iad_pkg::OP_GTE: item.simple = {31'd0, ~lts};
         iad_pkg::OP_LTE: item.simple = {31'd0, lts | (operand_a == operand_b)};
         iad_pkg::OP_SEXT: item.simple = sx;
         default: item.simple = '0;
      endcase
   end
endmodule

[rtl/iad_back.sv]
// Back end: pipelined multiply and radix-2 divide, one stage per quotient bit
`timescale 1ns / 1ps
module iad_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  iad_pkg::item_type in_item,
   input  logic              advance,
   output logic              out_valid,
   output iad_pkg::rsp_type  out_rsp
);
   localparam int unsigned N = iad_pkg::WORD;
   localparam int unsigned S = N + 3;

   typedef struct packed {
      iad_pkg::class_type cls;
      logic [4:0]  mode;
      logic        neg_q;
      logic        neg_r;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] q;
      logic [32:0] r;
      logic [31:0] d;
      logic [31:0] p0;
      logic [31:0] p1;
      logic [31:0] simple;
      logic        ovf;
      logic        dz;
   } stage_type;

   stage_type   st_ff [S];
   stage_type   st_in [S];
   logic [S-1:0] v_ff;
   logic [S-1:0] v_in;
   logic [31:0] sel;

   always_comb begin
      stage_type x;
      logic [32:0] t;
      logic [63:0] prod;
      logic        sd;
      x = '0;
      t = '0;
      prod = '0;
      sd = 1'b0;
      // stage 0: operand magnitudes
      x.cls = in_item.cls; x.mode = in_item.mode; x.a = in_item.a; x.b = in_item.b;
      x.simple = in_item.simple; x.ovf = in_item.ovf; x.dz = in_item.dz;
      sd = (in_item.mode == iad_pkg::OP_DIVS) || (in_item.mode == iad_pkg::OP_REMS);
      x.q = (sd && in_item.a[31]) ? 32'(-in_item.a) : in_item.a;
      x.d = (sd && in_item.b[31]) ? 32'(-in_item.b) : in_item.b;
      x.neg_q = sd & (in_item.a[31] ^ in_item.b[31]);
      x.neg_r = sd & in_item.a[31];
      x.r = '0;
      st_in[0] = x;
      // stage 1: product (divide starts its bit steps here too)
      for (int unsigned k = 1; k < S; k++) begin
         x = st_ff[k-1];
         if (k == 1) begin
            prod = {32'd0, x.a} * {32'd0, x.b};
            x.p0 = prod[31:0];
            x.p1 = prod[63:32];
         end else if (k == 2) begin
            if (x.mode == iad_pkg::OP_MULHS) begin
               x.p1 = x.p1 - (x.a[31] ? x.b : 32'd0) - (x.b[31] ? x.a : 32'd0);
            end
         end
         if (k <= N) begin
            t = {x.r[31:0], x.q[31]};
            x.q = {x.q[30:0], 1'b0};
            if (t >= {1'b0, x.d}) begin
               t = t - {1'b0, x.d};
               x.q[0] = 1'b1;
            end
            x.r = t;
         end else if (k == N + 1) begin
            if (x.neg_q) x.q = 32'(-x.q);
            if (x.neg_r) x.r = {1'b0, 32'(-x.r[31:0])};
         end
         st_in[k] = x;
      end
   end

   always_comb begin
      stage_type y;
      y = st_ff[S-1];
      case (y.cls)
         iad_pkg::CLS_MUL: sel = (y.mode == iad_pkg::OP_MULHS || y.mode == iad_pkg::OP_MULHU)
                                 ? y.p1 : y.p0;
         iad_pkg::CLS_DIV: sel = y.dz ? 32'd0 :
                                 ((y.mode == iad_pkg::OP_DIVS || y.mode == iad_pkg::OP_DIVU)
                                  ? y.q : y.r[31:0]);
         default: sel = y.simple;
      endcase
      out_rsp.result = sel;
      out_rsp.overflow = y.ovf;
      out_rsp.divide_by_zero = y.dz;
      out_valid = v_ff[S-1];
      v_in = {v_ff[S-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
      if (advance) begin
         for (int unsigned k = 0; k < S; k++) st_ff[k] <= st_in[k];
      end
   end
endmodule

[rtl/iad_queue.sv]
// Queue between the classifier and the execution pipeline
`timescale 1ns / 1ps
module iad_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iad_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output iad_pkg::item_type pop_item,
   output logic              empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   iad_pkg::item_type mem [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic do_push, do_pop;

   assign full = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign pop_item = mem[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (do_pop) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
      if (do_push) mem[wp_ff] <= push_item;
   end
endmodule

[rtl/integer_alu_with_divide_unit.sv]
// The queue feeds a 35-stage pipeline whose first stage loads as the queue pops; throughput
// is one transaction per cycle while the pipeline advances.
// Divide runs one quotient bit per stage over 32 stages; multiply is one stage plus a fixup.
// The pipeline advances only while its last stage is empty or being popped.
// Reset (synchronous) empties the queue and all pipeline stages.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module integer_alu_with_divide_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [4:0]  req_mode,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic [4:0]  req_shift_amount,
   input  logic [5:0]  req_extend_width,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_result,
   output logic        rsp_overflow,
   output logic        rsp_divide_by_zero
);
   iad_pkg::item_type fitem, qitem;
   iad_pkg::rsp_type  brsp;
   logic q_empty, bvalid, advance;

   iad_front u_front (
      .mode(req_mode), .operand_a(req_operand_a), .operand_b(req_operand_b),
      .shift_amount(req_shift_amount), .extend_width(req_extend_width), .item(fitem)
   );

   iad_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(fitem), .full(full),
      .pop(advance), .pop_item(qitem), .empty(q_empty)
   );

   // advance when last stage is free or taken
   assign advance = ~bvalid | pop;

   iad_back u_back (
      .clock(clock), .reset(reset), .in_valid(~q_empty), .in_item(qitem),
      .advance(advance), .out_valid(bvalid), .out_rsp(brsp)
   );

   assign empty = ~bvalid;
   assign rsp_result = brsp.result;
   assign rsp_overflow = brsp.overflow;
   assign rsp_divide_by_zero = brsp.divide_by_zero;

   `ASSERT_NEXT(a_hold, clock, reset, (~empty & ~pop), (~empty && $stable(rsp_result)))
   `ASSERT_IMPLY(a_flags, clock, reset, (~empty), (~(rsp_overflow & rsp_divide_by_zero)))
   `ASSERT_IMPLY(a_dz0, clock, reset, (~empty & rsp_divide_by_zero), (rsp_result == 32'd0))
endmodule
